/* rtl/fhs_pkg.sv */
// ----------------------------------------------------------------------------
// fhs_pkg: shared types and constants of the fragment header scanner
// Holds the header marks, the window type and the header test result.
// ----------------------------------------------------------------------------
package fhs_pkg;

	localparam int unsigned WIN_WORDS = 5;
	localparam int unsigned FRAG_BYTES = 32'h210;

	localparam logic [31:0] LIVE_MARK  = 32'h0000_0200;
	localparam logic [31:0] DEL_MARK   = 32'h0000_01FC;
	localparam logic [31:0] DEL_LENGTH = 32'h0000_0210;
	localparam logic [31:0] MAX_LENGTH = 32'h0000_0200;

	// Words of a fragment that are left once its header has been seen.
	localparam logic [6:0] SKIP_WORDS = 7'(FRAG_BYTES / 4 - WIN_WORDS);

	// Distance from the newest window word back to the oldest one.
	localparam logic [31:0] HEADER_BACK = 32'(4 * (WIN_WORDS - 1));

	localparam logic [2:0] FILL_FULL = 3'(WIN_WORDS);

	// Window words, index 0 is the oldest.
	typedef logic [WIN_WORDS-1:0][31:0] win_t;

	typedef struct packed {
		logic live;
		logic del;
	} chk_t;

endpackage

/* rtl/fhs_header_check.sv */
// ----------------------------------------------------------------------------
// fhs_header_check: fragment header test on a full window
// Flags a live or a deleted header, with the link checks against file size.
// ----------------------------------------------------------------------------
module fhs_header_check (
	input  fhs_pkg::win_t win,
	input  logic [31:0]   file_bytes,
	output fhs_pkg::chk_t chk
);

	function automatic logic link_ok(input logic [31:0] v, input logic [31:0] fs);
		return !v[31] && (v < fs) && (v[1:0] == 2'b00);
	endfunction

	logic fwd_ok;
	logic back_ok;

	always_comb begin
		fwd_ok  = link_ok(win[3], file_bytes) && (win[3] != win[0]);
		back_ok = link_ok(win[4], file_bytes);
		chk.live = (win[1] == fhs_pkg::LIVE_MARK) && (win[2] != 32'd0) &&
			(win[2] <= fhs_pkg::MAX_LENGTH) && fwd_ok;
		chk.del = (win[1] == fhs_pkg::DEL_MARK) && (win[2] == fhs_pkg::DEL_LENGTH) &&
			fwd_ok && back_ok;
	end

endmodule

/* rtl/fragment_header_scanner_core.sv */
// ----------------------------------------------------------------------------
// fragment_header_scanner_core: streaming fragment header scanner
// Finds live and deleted fragment headers in a stream of file words.
// ----------------------------------------------------------------------------
// The block takes one little-endian file word per request and reports every
// fragment header it finds, one result request per header. A request with
// tuser set starts a new scan at byte offset zero. Each word passes an input
// register, then the header logic, which updates the scan state and
// loads the output register, so a word is taken in every cycle as long as
// the result side keeps up; a result waiting on the master side stalls the
// input only once the input register is also full. After a hit the next 127
// words (the rest of the 0x210-byte fragment) are counted off without being
// tested. The file size register bounds link offsets; the user must write it
// only while no word is in flight, as the block itself does not enforce this.
module fragment_header_scanner_core (
	input  logic         clk,
	input  logic         arst_n,

	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,       // file_bytes

	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,         // [31:0] word
	input  logic         s_tuser,         // [0] restart

	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,         // [31:0] header_position,
	                                      // [63:32] offset_delta,
	                                      // [73:64] fragment_length,
	                                      // [104:74] next_link,
	                                      // [136:105] prev_link, rest zero
	output logic         m_tuser          // [0] is_deleted
);

	// Configuration.
	logic [31:0] file_bytes_q;

	// Input register.
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        restart_s1;

	// Scan state.
	fhs_pkg::win_t win_q;
	logic [2:0]    fill_q;
	logic [31:0]   pos_q;
	logic [6:0]    skip_q;

	// Output register.
	logic        out_valid_q;
	logic [31:0] out_pos_q;
	logic        out_del_q;
	logic [31:0] out_delta_q;
	logic [9:0]  out_len_q;
	logic [30:0] out_next_q;
	logic [31:0] out_prev_q;

	// Header logic.
	logic          proc;
	fhs_pkg::win_t win_base;
	fhs_pkg::win_t win_shift;
	fhs_pkg::win_t win_d;
	logic [2:0]    fill_base;
	logic [2:0]    fill_d;
	logic [31:0]   here;
	logic [6:0]    skip_base;
	logic [6:0]    skip_d;
	logic          test;
	logic          hit;
	logic [31:0]   hdr_pos;
	fhs_pkg::chk_t chk;

	// The header stage fires when the input register holds a word and the
	// output register is free or being emptied in this cycle.
	assign proc     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || proc;

	always_comb begin
		// A restart clears the scan state before its own word is taken.
		if (restart_s1) begin
			win_base  = '0;
			fill_base = 3'd0;
			here      = 32'd0;
			skip_base = 7'd0;
		end else begin
			win_base  = win_q;
			fill_base = fill_q;
			here      = pos_q;
			skip_base = skip_q;
		end

		win_shift = {word_s1, win_base[fhs_pkg::WIN_WORDS-1:1]};
		test      = 1'b0;
		win_d     = win_base;
		fill_d    = fill_base;
		skip_d    = skip_base;

		if (skip_base != 7'd0) begin
			skip_d = skip_base - 7'd1;
		end else begin
			win_d  = win_shift;
			fill_d = (fill_base < fhs_pkg::FILL_FULL) ? fill_base + 3'd1 : fill_base;
			test   = (fill_d == fhs_pkg::FILL_FULL);
		end

		hit = test && (chk.live || chk.del);
		if (hit) begin
			win_d  = '0;
			fill_d = 3'd0;
			skip_d = fhs_pkg::SKIP_WORDS;
		end

		hdr_pos = here - fhs_pkg::HEADER_BACK;
	end

	fhs_header_check u_check (
		.win        (win_shift),
		.file_bytes (file_bytes_q),
		.chk        (chk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_bytes_q <= 32'h8000_0000;
		end else if (cfg_we) begin
			file_bytes_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1    <= s_tdata;
			restart_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= 3'd0;
			pos_q  <= 32'd0;
			skip_q <= 7'd0;
		end else if (proc) begin
			win_q  <= win_d;
			fill_q <= fill_d;
			pos_q  <= here + 32'd4;
			skip_q <= skip_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= hit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && hit) begin
			out_pos_q   <= hdr_pos;
			out_del_q   <= chk.del;
			out_delta_q <= win_shift[0] - hdr_pos;
			out_len_q   <= win_shift[2][9:0];
			out_next_q  <= win_shift[3][30:0];
			out_prev_q  <= chk.del ? win_shift[4] : 32'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_del_q;
	assign m_tdata  = {7'd0, out_prev_q, out_next_q, out_len_q, out_delta_q, out_pos_q};

	// A hit always arms the fragment skip.
	a_hit_skip: assert property (@(posedge clk) disable iff (!arst_n)
		proc && hit |=> skip_q == fhs_pkg::SKIP_WORDS)
		else $error("skip not armed after a header hit");

	// No header is reported while a fragment is being skipped.
	a_skip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		proc && !restart_s1 && (skip_q != 7'd0) |=> !out_valid_q)
		else $error("result produced inside a skipped fragment");

	// The window never claims more words than it holds.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= fhs_pkg::FILL_FULL)
		else $error("fill count out of range");

	// A reported header never has a zero data length.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_len_q != 10'd0)
		else $error("reported header with zero length");

endmodule
